// ----- rtl/core/flashlight_mode_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Flashlight mode controller assertion macros
// Shared property wrappers clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FLASHLIGHT_MODE_CONTROLLER_DEFINES_SVH
`define FLASHLIGHT_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define FMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flashlight mode controller package
// Mode codes, register indexes, reset values, shared types and the duty lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package fmc_pkg;

  // Light modes in advance order
  typedef enum logic [1:0] {
    MODE_HIGH   = 2'd0,
    MODE_MEDIUM = 2'd1,
    MODE_LOW    = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  // Register indexes on the write port
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_LOW_BATT   = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_CHECK_PER  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_STABLE     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_DUTY_HIGH  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_DUTY_MED   = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_DUTY_LOW   = 3'd5;

  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Register reset values
  localparam logic [7:0] RST_LOW_BATT  = 8'd87;
  localparam logic [9:0] RST_CHECK_PER = 10'd100;
  localparam logic [7:0] RST_STABLE    = 8'd10;
  localparam logic [7:0] RST_DUTY_HIGH = 8'd255;
  localparam logic [7:0] RST_DUTY_MED  = 8'd25;
  localparam logic [7:0] RST_DUTY_LOW  = 8'd1;

  // Debouncer: previous sample code meaning no sample yet
  localparam logic [1:0] SAMPLE_NONE = 2'd3;

  typedef struct packed {
    logic [7:0] low_batt;
    logic [9:0] check_per;
    logic [7:0] stable;
    logic [7:0] duty_high;
    logic [7:0] duty_med;
    logic [7:0] duty_low;
  } cfg_t;

  // Debouncer status toward the mode logic and the result word
  typedef struct packed {
    logic fresh_press;
    logic held;
  } dbnc_t;

  function automatic logic [7:0] duty_of(mode_e mode, cfg_t cfg);
    logic [7:0] duty;
    case (mode)
      MODE_HIGH:   duty = cfg.duty_high;
      MODE_MEDIUM: duty = cfg.duty_med;
      MODE_LOW:    duty = cfg.duty_low;
      default:     duty = 8'd0;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/flashlight_mode_controller.sv -----
// ----------------------------------------------------------------------------
// Flashlight mode controller
// One tick word in, one result word out: debounced switch, mode and PWM duty.
// ----------------------------------------------------------------------------
// Each accepted input word is one 1 ms tick. The tick is processed in the
// cycle it is accepted and its result lands in a single output register, so
// the block takes one word per clock unless the output stalls, which holds
// the input off. s_axis_tready is high whenever the output register is empty
// or its word is taken in the same cycle. Registers must be written through
// cfg_we_i / cfg_addr_i / cfg_data_i only while no tick is in flight; the
// block does not enforce this. Writes to indexes above five are dropped.
`default_nettype none

module flashlight_mode_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tick word in
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [fmc_pkg::InDataW-1:0]     s_axis_tdata,   // [0] switch_level,
                                                               // [8:1] battery_reading
  // result word out
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [fmc_pkg::OutDataW-1:0]         m_axis_tdata,   // [7:0] pwm_duty,
                                                               // [9:8] mode_now,
                                                               // [10] switch_held
  // register write port
  input  wire logic                            cfg_we_i,
  input  wire logic [fmc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [fmc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import fmc_pkg::*;

  `include "flashlight_mode_controller_defines.svh"

  cfg_t                cfg_q;
  dbnc_t               dbnc;
  mode_e               mode_next;
  mode_e               mode_cur;
  logic                step;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_batt  <= RST_LOW_BATT;
      cfg_q.check_per <= RST_CHECK_PER;
      cfg_q.stable    <= RST_STABLE;
      cfg_q.duty_high <= RST_DUTY_HIGH;
      cfg_q.duty_med  <= RST_DUTY_MED;
      cfg_q.duty_low  <= RST_DUTY_LOW;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOW_BATT:  cfg_q.low_batt  <= cfg_data_i[7:0];
        REG_CHECK_PER: cfg_q.check_per <= cfg_data_i;
        REG_STABLE:    cfg_q.stable    <= cfg_data_i[7:0];
        REG_DUTY_HIGH: cfg_q.duty_high <= cfg_data_i[7:0];
        REG_DUTY_MED:  cfg_q.duty_med  <= cfg_data_i[7:0];
        REG_DUTY_LOW:  cfg_q.duty_low  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Tick handshake
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;

  fmc_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (s_axis_tdata[0]),
    .stable_i (cfg_q.stable),
    .status_o (dbnc)
  );

  fmc_mode u_mode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .fresh_press_i (dbnc.fresh_press),
    .reading_i     (s_axis_tdata[8:1]),
    .cfg_i         (cfg_q),
    .mode_next_o   (mode_next),
    .mode_o        (mode_cur)
  );

  // Result word
  assign out_data_d = {5'd0, dbnc.held, mode_next, duty_of(mode_next, cfg_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `FMC_ASSERT_NOW(a_off_dark, m_axis_tvalid && m_axis_tdata[9:8] == MODE_OFF,
                  m_axis_tdata[7:0] == 8'd0, "off mode shows nonzero duty")
  `FMC_ASSERT_NEXT(a_tick_lands, step, m_axis_tvalid, "accepted tick produced no result")
  `FMC_ASSERT_NEXT(a_mode_idle, !step, $stable(mode_cur), "mode changed without a tick")
  `FMC_ASSERT_NEXT(a_mode_match, step, m_axis_tdata[9:8] == mode_cur,
                   "result mode differs from mode register")

endmodule

`default_nettype wire

// ----- rtl/core/fmc_debounce.sv -----
// ----------------------------------------------------------------------------
// Flashlight switch debouncer
// Accepts a switch level after a run of equal samples; flags a new press.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_debounce (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,      // one tick accepted
  input  wire logic         level_i,     // raw level, 0 pressed
  input  wire logic [7:0]   stable_i,
  output fmc_pkg::dbnc_t    status_o     // status after this tick
);
  import fmc_pkg::*;

  logic [7:0] run_q, run_d;
  logic [1:0] prev_q, prev_d;
  logic       held_q, held_d;
  logic       fresh_press;
  logic [7:0] run_dec;

  // Run count and accepted level
  always_comb begin
    run_dec     = run_q - 8'd1;
    run_d       = run_q;
    prev_d      = prev_q;
    held_d      = held_q;
    fresh_press = 1'b0;
    if ({1'b0, level_i} == prev_q) begin
      run_d = run_dec;
      if (run_dec == 8'd0) begin
        run_d = stable_i;
        if (level_i) begin
          held_d = 1'b0;
        end else begin
          fresh_press = ~held_q;
          held_d      = 1'b1;
        end
      end
    end else begin
      run_d  = stable_i;
      prev_d = {1'b0, level_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= RST_STABLE;
      prev_q <= SAMPLE_NONE;
      held_q <= 1'b0;
    end else if (step_i) begin
      run_q  <= run_d;
      prev_q <= prev_d;
      held_q <= held_d;
    end
  end

  assign status_o.fresh_press = fresh_press;
  assign status_o.held        = held_d;

endmodule

`default_nettype wire

// ----- rtl/core/fmc_mode.sv -----
// ----------------------------------------------------------------------------
// Flashlight mode sequencer
// Battery check period counter, low-battery step down and press advance.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_mode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           fresh_press_i,
  input  wire logic [7:0]     reading_i,
  input  wire fmc_pkg::cfg_t  cfg_i,
  output fmc_pkg::mode_e      mode_next_o,  // mode after this tick
  output fmc_pkg::mode_e      mode_o        // registered mode
);
  import fmc_pkg::*;

  mode_e      mode_q, mode_d;
  logic [9:0] cnt_q, cnt_d;
  logic [9:0] cnt_inc;
  logic       check;

  // Period counter holds while off
  always_comb begin
    cnt_inc = cnt_q + 10'd1;
    cnt_d   = cnt_q;
    check   = 1'b0;
    if (mode_q != MODE_OFF) begin
      cnt_d = cnt_inc;
      if (cnt_inc == cfg_i.check_per) begin
        cnt_d = 10'd0;
        check = 1'b1;
      end
    end
  end

  // Step down on low battery, then advance on a new press
  always_comb begin
    mode_d = mode_q;
    if (check && mode_q == MODE_HIGH && reading_i > cfg_i.low_batt) begin
      mode_d = MODE_MEDIUM;
    end
    if (fresh_press_i) begin
      mode_d = mode_e'(mode_d + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HIGH;
      cnt_q  <= 10'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  assign mode_next_o = mode_d;
  assign mode_o      = mode_q;

endmodule

`default_nettype wire
